// ----- sv/fuzzy_subsequence_scorer_top_assert.svh -----
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer: assertion macros
// Shared concurrent assertion forms used by the scorer modules.
// ----------------------------------------------------------------------------
`ifndef FUZZY_SUBSEQUENCE_SCORER_TOP_ASSERT_SVH
`define FUZZY_SUBSEQUENCE_SCORER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FSS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("fuzzy subsequence scorer: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define FSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("fuzzy subsequence scorer: next-cycle check failed");

`endif

// ----- sv/fss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_pkg
// Constants, types and helper functions shared by the fuzzy subsequence scorer.
// ----------------------------------------------------------------------------
package fss_pkg;

	localparam int MAX_PATTERN = 64;
	localparam int MAX_TEXT    = 512;

	localparam int PAT_AW   = $clog2(MAX_PATTERN);
	localparam int MCNT_W   = 7;
	localparam int TPOS_W   = 10;
	localparam int MPOS_W   = 9;
	localparam int CHAR_W   = 8;
	localparam int LEN_W    = 7;
	localparam int WGT_W    = 8;
	localparam int SCORE_W  = 17;
	localparam int CIDX_W   = 2;
	localparam int CDATA_W  = 8;

	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

	// Opcodes of an input transaction.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEXT = 1'b1;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
	localparam logic [CIDX_W-1:0] REG_START_WEIGHT   = 2'd1;
	localparam logic [CIDX_W-1:0] REG_GAP_PENALTY    = 2'd2;

	localparam logic [LEN_W-1:0] RST_PATTERN_LENGTH = 7'd0;
	localparam logic [WGT_W-1:0] RST_START_WEIGHT   = 8'd100;
	localparam logic [WGT_W-1:0] RST_GAP_PENALTY    = 8'd50;

	typedef struct packed {
		logic [LEN_W-1:0] pattern_length;
		logic [WGT_W-1:0] start_weight;
		logic [WGT_W-1:0] gap_penalty;
	} cfg_t;

	// End-of-text summary handed from the match engine to the result stage.
	typedef struct packed {
		logic              valid;
		logic              found;
		logic              scored;
		logic [MPOS_W-1:0] first_pos;
		logic [MPOS_W-1:0] latest_pos;
		logic              contiguous;
	} text_end_t;

	function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

// ----- sv/fss_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_if
// Channel interfaces of the scorer: text input, result output, configuration.
// ----------------------------------------------------------------------------
interface fss_in_if
	import fss_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [PAT_AW-1:0] pattern_index;
	logic [CHAR_W-1:0] char_value;
	logic              has_char;
	logic              last;

	modport source (output valid, opcode, pattern_index, char_value, has_char, last,
		input ready);
	modport sink (input valid, opcode, pattern_index, char_value, has_char, last,
		output ready);
endinterface

interface fss_out_if
	import fss_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               found;
	logic [SCORE_W-1:0] score;

	modport source (output valid, found, score, input ready);
	modport sink (input valid, found, score, output ready);
endinterface

interface fss_cfg_if
	import fss_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [CIDX_W-1:0]  index;
	logic [CDATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/fss_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_cfg
// Configuration register file: pattern length, start weight, gap penalty.
// ----------------------------------------------------------------------------
module fss_cfg
	import fss_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	fss_cfg_if.sink   cfg,
	output cfg_t      regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.pattern_length <= RST_PATTERN_LENGTH;
			regs_q.start_weight   <= RST_START_WEIGHT;
			regs_q.gap_penalty    <= RST_GAP_PENALTY;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PATTERN_LENGTH: regs_q.pattern_length <= cfg.data[LEN_W-1:0];
				REG_START_WEIGHT:   regs_q.start_weight   <= cfg.data[WGT_W-1:0];
				REG_GAP_PENALTY:    regs_q.gap_penalty    <= cfg.data[WGT_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- sv/fss_engine.sv -----
`timescale 1ns / 1ps
`include "fuzzy_subsequence_scorer_top_assert.svh"
// ----------------------------------------------------------------------------
// fss_engine
// Input register, pattern memory and greedy match state for the text stream.
// ----------------------------------------------------------------------------
module fss_engine
	import fss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	fss_in_if.sink     text_in,
	input  cfg_t       regs,
	input  logic       res_free,
	output text_end_t  text_end
);

	// Input register stage.
	logic              v_s1;
	logic              op_s1;
	logic [PAT_AW-1:0] idx_s1;
	logic [CHAR_W-1:0] ch_s1;
	logic              has_s1;
	logic              last_s1;

	// Match state.
	logic [TPOS_W-1:0] tpos_q;
	logic [MCNT_W-1:0] mcnt_q;
	logic [MPOS_W-1:0] first_q;
	logic [MPOS_W-1:0] latest_q;
	logic              contig_q;

	// Pattern memory with registered read of the entry at the match count.
	logic [CHAR_W-1:0] pat_mem [MAX_PATTERN];
	logic [CHAR_W-1:0] pat_rd_q;
	logic [PAT_AW-1:0] rd_addr;

	logic              ends_text;
	logic              go;
	logic              text_step;
	logic              text_done;
	logic              counted;
	logic              hit;
	logic              wr_en;
	logic [MCNT_W-1:0] len_used;
	logic [TPOS_W-1:0] tpos_n;
	logic [MCNT_W-1:0] mcnt_n;
	logic [MPOS_W-1:0] first_n;
	logic [MPOS_W-1:0] latest_n;
	logic              contig_n;
	logic              complete;

	assign ends_text     = (op_s1 == OP_TEXT) && last_s1;
	assign go            = v_s1 && (!ends_text || res_free);
	assign text_in.ready = !v_s1 || go;

	assign len_used = (regs.pattern_length > MCNT_W'(MAX_PATTERN)) ?
		MCNT_W'(MAX_PATTERN) : regs.pattern_length;

	assign text_step = go && (op_s1 == OP_TEXT);
	assign text_done = text_step && last_s1;
	assign counted   = text_step && has_s1 && (tpos_q < TPOS_W'(MAX_TEXT));
	assign hit       = counted && (mcnt_q < len_used) &&
		(fold_case(ch_s1) == fold_case(pat_rd_q));
	assign wr_en     = go && (op_s1 == OP_LOAD);

	always_comb begin
		tpos_n   = counted ? tpos_q + TPOS_W'(1) : tpos_q;
		mcnt_n   = mcnt_q;
		first_n  = first_q;
		latest_n = latest_q;
		contig_n = contig_q;
		if (hit) begin
			if (mcnt_q == '0) begin
				first_n = tpos_q[MPOS_W-1:0];
			end else if (tpos_q != ({1'b0, latest_q} + TPOS_W'(1))) begin
				contig_n = 1'b0;
			end
			latest_n = tpos_q[MPOS_W-1:0];
			mcnt_n   = mcnt_q + MCNT_W'(1);
		end
	end

	assign complete = (mcnt_n >= len_used);

	// A finished text restarts matching at the first pattern entry.
	assign rd_addr = text_done ? '0 : mcnt_n[PAT_AW-1:0];

	assign text_end.valid      = text_done;
	assign text_end.found      = complete;
	assign text_end.scored     = complete && (len_used != '0);
	assign text_end.first_pos  = first_n;
	assign text_end.latest_pos = latest_n;
	assign text_end.contiguous = contig_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (text_in.valid && text_in.ready) begin
			v_s1 <= 1'b1;
		end else if (go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.valid && text_in.ready) begin
			op_s1   <= text_in.opcode;
			idx_s1  <= text_in.pattern_index;
			ch_s1   <= text_in.char_value;
			has_s1  <= text_in.has_char;
			last_s1 <= text_in.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpos_q   <= '0;
			mcnt_q   <= '0;
			first_q  <= '0;
			latest_q <= '0;
			contig_q <= 1'b1;
		end else if (text_done) begin
			tpos_q   <= '0;
			mcnt_q   <= '0;
			first_q  <= '0;
			latest_q <= '0;
			contig_q <= 1'b1;
		end else begin
			tpos_q   <= tpos_n;
			mcnt_q   <= mcnt_n;
			first_q  <= first_n;
			latest_q <= latest_n;
			contig_q <= contig_n;
		end
	end

	// A load to the entry being fetched is forwarded so the next compare sees it.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pat_mem[idx_s1] <= ch_s1;
		end
		if (wr_en && (idx_s1 == rd_addr)) begin
			pat_rd_q <= ch_s1;
		end else begin
			pat_rd_q <= pat_mem[rd_addr];
		end
	end

	`FSS_ASSERT_SAME(a_first_not_after_latest, clk, arst_n, mcnt_q != '0, latest_q >= first_q)
	`FSS_ASSERT_SAME(a_count_within_position, clk, arst_n, 1'b1, TPOS_W'(mcnt_q) <= tpos_q)
	`FSS_ASSERT_NEXT(a_end_clears_state, clk, arst_n, text_done, (mcnt_q == '0) && (tpos_q == '0) && contig_q)

endmodule

// ----- sv/fss_result.sv -----
`timescale 1ns / 1ps
`include "fuzzy_subsequence_scorer_top_assert.svh"
// ----------------------------------------------------------------------------
// fss_result
// Score computation and the output register of the result channel.
// ----------------------------------------------------------------------------
module fss_result
	import fss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  text_end_t  text_end,
	input  cfg_t       regs,
	output logic       res_free,
	fss_out_if.source  result_out
);

	logic               vld_q;
	logic               found_q;
	logic [SCORE_W-1:0] score_q;

	logic [SCORE_W-1:0] prod;
	logic [MPOS_W-1:0]  span;
	logic [SCORE_W:0]   sum;
	logic [SCORE_W-1:0] score_d;

	assign prod = SCORE_W'(text_end.first_pos) * SCORE_W'(regs.start_weight);
	assign span = text_end.latest_pos - text_end.first_pos;
	assign sum  = {1'b0, prod} + (SCORE_W + 1)'(span) +
		(text_end.contiguous ? '0 : (SCORE_W + 1)'(regs.gap_penalty));

	always_comb begin
		if (!text_end.scored) begin
			score_d = '0;
		end else if (sum > {1'b0, SCORE_MAX}) begin
			score_d = SCORE_MAX;
		end else begin
			score_d = sum[SCORE_W-1:0];
		end
	end

	assign res_free          = !vld_q || result_out.ready;
	assign result_out.valid  = vld_q;
	assign result_out.found  = found_q;
	assign result_out.score  = score_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (text_end.valid) begin
			vld_q <= 1'b1;
		end else if (result_out.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_end.valid) begin
			found_q <= text_end.found;
			score_q <= score_d;
		end
	end

	`FSS_ASSERT_SAME(a_no_score_without_found, clk, arst_n, vld_q && !found_q, score_q == '0)
	`FSS_ASSERT_SAME(a_end_only_into_free_slot, clk, arst_n, text_end.valid, res_free)

endmodule

// ----- sv/fuzzy_subsequence_scorer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer_top
// Greedy case-insensitive subsequence match of a stored pattern against a
// byte stream, with a score for the match on the last text byte.
// ----------------------------------------------------------------------------
//  Channel      Direction  Payload
//  text_in      sink       opcode, pattern_index, char_value, has_char, last
//  result_out   source     found, score
//  cfg          sink       index, data (always ready)
//
//  One transaction is accepted per cycle unless a text end waits on a stalled
//  result; the last text byte goes through the input register, then the result
//  register. The pattern memory read is registered at the next match count, so
//  consecutive matching bytes cause no stall.
//  Reset clears the match state and valid flags and sets the configuration defaults; pattern bytes must be loaded.
//  A stalled result holds only the input stage while a new text ends.
module fuzzy_subsequence_scorer_top
	import fss_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	fss_in_if.sink    text_in,
	fss_out_if.source result_out,
	fss_cfg_if.sink   cfg
);

	cfg_t      regs;
	text_end_t text_end;
	logic      res_free;

	fss_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	fss_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_in),
		.regs     (regs),
		.res_free (res_free),
		.text_end (text_end)
	);

	fss_result u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_end   (text_end),
		.regs       (regs),
		.res_free   (res_free),
		.result_out (result_out)
	);

endmodule
